// ===== rtl/pkbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pkbs_pkg
// shared constants, register codes and result types of the key blank sequencer
// ----------------------------------------------------------------------------
package pkbs_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int FLAG_W    = 4;
	localparam int BRI_W     = 8;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_POLL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH  = 2'd2;

	// register reset values
	localparam logic [CFG_W-1:0] POLL_RST     = 16'd20;
	localparam logic [CFG_W-1:0] FALLBACK_RST = 16'd1500;
	localparam logic [CFG_W-1:0] REFRESH_RST  = 16'd100;

	// key event flag bits
	localparam logic [FLAG_W-1:0] F_RELEASE = 4'h1;
	localparam logic [FLAG_W-1:0] F_PRESS   = 4'h2;
	localparam logic [FLAG_W-1:0] F_LONG    = 4'h4;

	typedef struct packed {
		logic              polled;
		logic [FLAG_W-1:0] clear_flags;
		logic              send_frame;
		logic [BRI_W-1:0]  frame_brightness;
		logic              render_enable;
		logic              blank_now;
		logic [FLAG_W-1:0] trigger_flags;
		logic [FLAG_W-1:0] recent_flags;
		logic              last_in_run;
	} res_t;

	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} step_out_t;

endpackage

// ===== rtl/pkbs_if.sv =====
// ----------------------------------------------------------------------------
// pkbs_if
// valid/ready channels for tick items and result items
// ----------------------------------------------------------------------------
interface pkbs_in_if import pkbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status_ok;
	logic [FLAG_W-1:0] key_flags;
	logic [BRI_W-1:0]  logical_brightness;

	modport source(output valid, output status_ok, output key_flags,
		output logical_brightness, input ready);
	modport sink(input valid, input status_ok, input key_flags,
		input logical_brightness, output ready);
endinterface

interface pkbs_out_if import pkbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              polled;
	logic [FLAG_W-1:0] clear_flags;
	logic              send_frame;
	logic [BRI_W-1:0]  frame_brightness;
	logic              render_enable;
	logic              blank_now;
	logic [FLAG_W-1:0] trigger_flags;
	logic [FLAG_W-1:0] recent_flags;
	logic              last_in_run;

	modport source(output valid, output polled, output clear_flags, output send_frame,
		output frame_brightness, output render_enable, output blank_now,
		output trigger_flags, output recent_flags, output last_in_run, input ready);
	modport sink(input valid, input polled, input clear_flags, input send_frame,
		input frame_brightness, input render_enable, input blank_now,
		input trigger_flags, input recent_flags, input last_in_run, output ready);
endinterface

// ===== rtl/pkbs_step.sv =====
// ----------------------------------------------------------------------------
// pkbs_step
// config registers, sequencer state and the per-tick next-state/result logic
// ----------------------------------------------------------------------------
module pkbs_step import pkbs_pkg::*; #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 commit,
	input  logic                 status_ok,
	input  logic [FLAG_W-1:0]    key_flags,
	input  logic [BRI_W-1:0]     logical_brightness,
	output step_out_t            step_out
);

	localparam int TW = TIMER_WIDTH;
	localparam int CW = (TW > CFG_W) ? TW : CFG_W;

	logic [CFG_W-1:0]  poll_int_q, fallback_q, refresh_int_q;
	logic [TW-1:0]     poll_q, hold_q, refr_q;
	logic              held_q, timing_q, blank_q;
	logic [BRI_W-1:0]  saved_q;
	logic [FLAG_W-1:0] trig_q, lflags_q;

	logic [TW-1:0]     poll_inc, hold_inc, refr_inc;
	logic              poll_hit, do_poll;

	logic [TW-1:0]     poll_n, hold_n, refr_n;
	logic              held_n, timing_n, blank_n, rel, ev_blank, ev_second;
	logic [BRI_W-1:0]  saved_n, sec_bri;
	logic [FLAG_W-1:0] trig_n, lflags_n, clear;
	res_t              base;

	// saturating timers
	assign poll_inc = (poll_q == '1) ? poll_q : TW'(poll_q + 1'b1);
	assign hold_inc = (hold_q == '1) ? hold_q : TW'(hold_q + 1'b1);
	assign refr_inc = (refr_q == '1) ? refr_q : TW'(refr_q + 1'b1);

	assign poll_hit = CW'(poll_inc) >= CW'(poll_int_q);
	assign do_poll  = poll_hit && status_ok;
	assign clear    = do_poll ? key_flags : '0;
	assign lflags_n = (do_poll && key_flags != '0) ? key_flags : lflags_q;

	always_comb begin
		poll_n    = poll_hit ? '0 : poll_inc;
		hold_n    = hold_inc;
		refr_n    = refr_inc;
		held_n    = held_q;
		timing_n  = timing_q;
		blank_n   = blank_q;
		saved_n   = saved_q;
		trig_n    = trig_q;
		rel       = 1'b0;
		ev_blank  = 1'b0;
		ev_second = 1'b0;
		sec_bri   = '0;
		if (do_poll) begin
			if ((key_flags & F_PRESS) != '0) begin
				held_n   = 1'b1;
				timing_n = 1'b1;
				hold_n   = '0;
			end
			if ((key_flags & F_LONG) != '0 && !blank_n) begin
				held_n = 1'b1;
				if (!timing_n) begin
					timing_n = 1'b1;
					hold_n   = '0;
				end
				trig_n   = key_flags;
				saved_n  = logical_brightness;
				blank_n  = 1'b1;
				refr_n   = '0;
				ev_blank = 1'b1;
			end
			// fallback: long enough hold without a long-press event
			if (held_n && !blank_n && timing_n && CW'(hold_n) >= CW'(fallback_q)) begin
				trig_n   = F_PRESS;
				saved_n  = logical_brightness;
				blank_n  = 1'b1;
				refr_n   = '0;
				ev_blank = 1'b1;
			end
			if ((key_flags & F_RELEASE) != '0) begin
				held_n   = 1'b0;
				timing_n = 1'b0;
				hold_n   = '0;
				rel      = 1'b1;
				if (blank_n) begin
					blank_n   = 1'b0;
					ev_second = 1'b1;
					sec_bri   = (logical_brightness != '0) ? logical_brightness : saved_n;
				end
			end
		end
		// repeated zero frame while blanked and held
		if (!rel && blank_n && held_n && CW'(refr_n) >= CW'(refresh_int_q)) begin
			refr_n    = '0;
			ev_second = 1'b1;
			sec_bri   = '0;
		end
	end

	always_comb begin
		base.polled           = do_poll;
		base.clear_flags      = clear;
		base.send_frame       = ev_second;
		base.frame_brightness = sec_bri;
		base.render_enable    = !blank_n;
		base.blank_now        = blank_n;
		base.trigger_flags    = trig_n;
		base.recent_flags     = lflags_n;
		base.last_in_run      = 1'b1;

		step_out.two = ev_blank && ev_second;
		step_out.r1  = base;
		step_out.r0  = base;
		if (ev_blank) begin
			step_out.r0.send_frame       = 1'b1;
			step_out.r0.frame_brightness = '0;
			step_out.r0.render_enable    = 1'b0;
			step_out.r0.blank_now        = 1'b1;
			step_out.r0.last_in_run      = !ev_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_int_q    <= POLL_RST;
			fallback_q    <= FALLBACK_RST;
			refresh_int_q <= REFRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL:     poll_int_q    <= cfg_data;
				REG_FALLBACK: fallback_q    <= cfg_data;
				REG_REFRESH:  refresh_int_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q   <= '0;
			hold_q   <= '0;
			refr_q   <= '0;
			held_q   <= 1'b0;
			timing_q <= 1'b0;
			blank_q  <= 1'b0;
			saved_q  <= '0;
			trig_q   <= '0;
			lflags_q <= '0;
		end else if (commit) begin
			poll_q   <= poll_n;
			hold_q   <= hold_n;
			refr_q   <= refr_n;
			held_q   <= held_n;
			timing_q <= timing_n;
			blank_q  <= blank_n;
			saved_q  <= saved_n;
			trig_q   <= trig_n;
			lflags_q <= lflags_n;
		end
	end

	// the head result never enables rendering while it reports the display blanked
	assert property (@(posedge clk) disable iff (!arst_n) blank_q |-> !step_out.r0.render_enable
		|| !step_out.r0.blank_now) else $error("render enabled while blanked");

	// a two-result tick is always a blank followed by another frame
	assert property (@(posedge clk) disable iff (!arst_n) step_out.two |->
		(step_out.r0.send_frame && step_out.r1.send_frame && !step_out.r0.last_in_run))
		else $error("two-result tick malformed");

	// a committed release leaves the key not held
	assert property (@(posedge clk) disable iff (!arst_n)
		commit && do_poll && ((key_flags & F_RELEASE) != '0) |=> !held_q)
		else $error("release did not clear hold");

endmodule

// ===== rtl/pkbs_res_buf.sv =====
// ----------------------------------------------------------------------------
// pkbs_res_buf
// two-slot result register, hands results out one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module pkbs_res_buf import pkbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  step_out_t  step_out,
	output logic       can_load,
	pkbs_out_if.source out_ch
);

	logic [1:0] cnt_q;
	res_t       slot0_q, slot1_q;
	logic       fire;

	assign fire     = out_ch.valid && out_ch.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step_out.two ? 2'd2 : 2'd1;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= step_out.r0;
			slot1_q <= step_out.r1;
		end else if (fire) begin
			slot0_q <= slot1_q;
		end
	end

	assign out_ch.valid            = (cnt_q != 2'd0);
	assign out_ch.polled           = slot0_q.polled;
	assign out_ch.clear_flags      = slot0_q.clear_flags;
	assign out_ch.send_frame       = slot0_q.send_frame;
	assign out_ch.frame_brightness = slot0_q.frame_brightness;
	assign out_ch.render_enable    = slot0_q.render_enable;
	assign out_ch.blank_now        = slot0_q.blank_now;
	assign out_ch.trigger_flags    = slot0_q.trigger_flags;
	assign out_ch.recent_flags     = slot0_q.recent_flags;
	assign out_ch.last_in_run      = slot0_q.last_in_run;

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result count overflow");

	// the head slot closes the run exactly when it is the only one left
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> (slot0_q.last_in_run == (cnt_q == 2'd1)))
		else $error("last_in_run out of step with count");

	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && fire)))
		else $error("load over pending results");

endmodule

// ===== rtl/power_key_safe_blank_sequencer.sv =====
// a tick item passes the input register stage, then the two-slot result register
// throughput: one item per cycle with one result per item and the receiver ready
// the result register sets the pace: it drains one result per cycle while out_ch.ready
// the input takes a new item while results wait, through the input register stage
// reset: arst_n clears all timers and state, and loads the interval registers
// ----------------------------------------------------------------------------
// power_key_safe_blank_sequencer
// key-event poller that blanks the display on a long hold and restores it
// on release
// ----------------------------------------------------------------------------
module power_key_safe_blank_sequencer import pkbs_pkg::*; #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pkbs_in_if.sink              in_ch,
	pkbs_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// input register stage
	logic              valid_s1;
	logic              status_ok_s1;
	logic [FLAG_W-1:0] key_flags_s1;
	logic [BRI_W-1:0]  bri_s1;

	logic      in_fire, advance, can_load;
	step_out_t step_out;

	// the stage moves on whenever the result register can take the item's results
	assign advance     = valid_s1 && can_load;
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_ok_s1 <= in_ch.status_ok;
			key_flags_s1 <= in_ch.key_flags;
			bri_s1       <= in_ch.logical_brightness;
		end
	end

	// timers, hold/blank state and the per-tick decision; state commits on advance
	pkbs_step #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_step (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.commit            (advance),
		.status_ok         (status_ok_s1),
		.key_flags         (key_flags_s1),
		.logical_brightness(bri_s1),
		.step_out          (step_out)
	);

	// one or two results per tick, handed out in order
	pkbs_res_buf u_res_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.step_out(step_out),
		.can_load(can_load),
		.out_ch  (out_ch)
	);

	// a held item waits in place until the results ahead of it drain
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1) else $error("tick item dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !advance |-> !valid_s1) else $error("tick item overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_ch.valid) else $error("advanced tick produced no result");

endmodule

// ===== tb/sv/tb_power_key_safe_blank_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_power_key_safe_blank_sequencer
// drives millisecond tick items into the key blank sequencer, predicts every
// status item it should return, and checks them in order as they come out,
// under random sender gaps, receiver stalls and several interval settings
// ----------------------------------------------------------------------------
module tb_power_key_safe_blank_sequencer import pkbs_pkg::*; ();

	localparam int TMR_W       = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF    = 80;
	localparam int SHOWN_MAX   = 10;

	// short-press bit, not named in the package
	localparam logic [FLAG_W-1:0] F_SHORT = 4'h8;
	localparam logic [FLAG_W-1:0] F_NONE  = 4'h0;
	localparam logic [FLAG_W-1:0] F_EVERY = 4'hF;

	// golden model of the sequencer plus the in-order store of status items
	class blank_scoreboard;
		bit [CFG_W-1:0]  poll_ivl;
		bit [CFG_W-1:0]  hold_limit;
		bit [CFG_W-1:0]  refresh_ivl;
		bit [TMR_W-1:0]  poll_cnt;
		bit [TMR_W-1:0]  hold_cnt;
		bit [TMR_W-1:0]  refresh_cnt;
		bit              held;
		bit              hold_run;
		bit              blanked;
		bit [BRI_W-1:0]  saved_bri;
		bit [FLAG_W-1:0] trig;
		bit [FLAG_W-1:0] seen_flags;
		res_t            tick_status[2];
		int              n_tick;
		bit              cur_polled;
		bit [FLAG_W-1:0] cur_clear;
		res_t            awaited_status[$];
		int              mismatches;

		function new();
			poll_ivl    = POLL_RST;
			hold_limit  = FALLBACK_RST;
			refresh_ivl = REFRESH_RST;
			poll_cnt    = '0;
			hold_cnt    = '0;
			refresh_cnt = '0;
			held        = 1'b0;
			hold_run    = 1'b0;
			blanked     = 1'b0;
			saved_bri   = '0;
			trig        = '0;
			seen_flags  = '0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_POLL:     poll_ivl    = val;
				REG_FALLBACK: hold_limit  = val;
				REG_REFRESH:  refresh_ivl = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited_status.size();
		endfunction

		function bit [TMR_W-1:0] bump(bit [TMR_W-1:0] t);
			return (t == '1) ? t : t + 1'b1;
		endfunction

		// one status item of this tick, taken after its action
		function void push_status(bit frame, bit [BRI_W-1:0] bri);
			res_t r;
			if (n_tick >= 2)
				return;
			r                  = '0;
			r.polled           = cur_polled;
			r.clear_flags      = cur_clear;
			r.send_frame       = frame;
			r.frame_brightness = frame ? bri : '0;
			r.render_enable    = !blanked;
			r.blank_now        = blanked;
			r.trigger_flags    = trig;
			r.recent_flags     = seen_flags;
			r.last_in_run      = 1'b0;
			tick_status[n_tick] = r;
			n_tick++;
		endfunction

		function void start_blank(bit [FLAG_W-1:0] cause, bit [BRI_W-1:0] bri);
			if (blanked)
				return;
			trig        = cause;
			saved_bri   = bri;
			blanked     = 1'b1;
			refresh_cnt = '0;
			push_status(1'b1, '0);
		endfunction

		// zero frame repeat while blanked and held
		function void refresh_due();
			if (!blanked || !held)
				return;
			if (refresh_cnt < refresh_ivl)
				return;
			refresh_cnt = '0;
			push_status(1'b1, '0);
		endfunction

		function void note_tick(bit ok, bit [FLAG_W-1:0] flags, bit [BRI_W-1:0] bri);
			n_tick      = 0;
			cur_polled  = 1'b0;
			cur_clear   = '0;
			poll_cnt    = bump(poll_cnt);
			hold_cnt    = bump(hold_cnt);
			refresh_cnt = bump(refresh_cnt);
			if (poll_cnt >= poll_ivl) begin
				poll_cnt = '0;
				if (!ok) begin
					refresh_due();
				end else begin
					cur_polled = 1'b1;
					if (flags != F_NONE) begin
						seen_flags = flags;
						cur_clear  = flags;
					end
					if ((flags & F_PRESS) != F_NONE) begin
						held     = 1'b1;
						hold_run = 1'b1;
						hold_cnt = '0;
					end
					if ((flags & F_LONG) != F_NONE && !blanked) begin
						held = 1'b1;
						if (!hold_run) begin
							hold_run = 1'b1;
							hold_cnt = '0;
						end
						start_blank(flags, bri);
					end
					if (held && !blanked && hold_run && hold_cnt >= hold_limit)
						start_blank(F_PRESS, bri);
					if ((flags & F_RELEASE) != F_NONE) begin
						held     = 1'b0;
						hold_run = 1'b0;
						hold_cnt = '0;
						if (blanked) begin
							blanked = 1'b0;
							push_status(1'b1, (bri == '0) ? saved_bri : bri);
						end
					end else begin
						refresh_due();
					end
				end
			end else begin
				refresh_due();
			end
			if (n_tick == 0)
				push_status(1'b0, '0);
			tick_status[n_tick-1].last_in_run = 1'b1;
			for (int i = 0; i < n_tick; i++)
				awaited_status.push_back(tick_status[i]);
		endfunction

		function string show(res_t r);
			return $sformatf({"pol=%0d clr=%h frm=%0d bri=%0d ren=%0d blk=%0d ",
				"trg=%h rec=%h last=%0d"}, r.polled, r.clear_flags, r.send_frame,
				r.frame_brightness, r.render_enable, r.blank_now, r.trigger_flags,
				r.recent_flags, r.last_in_run);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited_status.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("unexpected status item: %s", show(got));
				return;
			end
			want = awaited_status.pop_front();
			if (got.polled !== want.polled || got.clear_flags !== want.clear_flags ||
				got.send_frame !== want.send_frame ||
				got.frame_brightness !== want.frame_brightness ||
				got.render_enable !== want.render_enable ||
				got.blank_now !== want.blank_now ||
				got.trigger_flags !== want.trigger_flags ||
				got.recent_flags !== want.recent_flags ||
				got.last_in_run !== want.last_in_run) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX) begin
					$display("status mismatch at %0t", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	pkbs_in_if  in_ch ();
	pkbs_out_if out_ch ();

	power_key_safe_blank_sequencer #(.TIMER_WIDTH(TMR_W)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blank_scoreboard sb = new();

	// idle odds in percent for each side, changed between phases
	int sender_idle_pct;
	int receiver_idle_pct;
	// long receiver hold-off, requested by the stimulus, run by the receiver
	bit pressure_req;
	int hold_off_left;
	int ticks_sent;
	int cycle_count;
	res_t seen_status;

	// 12 unit clock period
	always #6 clk = ~clk;

	// safety net: the run never takes this long when the block behaves
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_power_key_safe_blank_sequencer: done, errors");
			$finish;
		end
	end

	// result side: ready changes on the falling edge only
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			// long stall so the result register fills and the input backs up
			out_ch.ready <= 1'b0;
			hold_off_left--;
		end else if (pressure_req) begin
			pressure_req  = 1'b0;
			hold_off_left = HOLD_OFF - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
		end
	end

	// every accepted status item goes to the checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen_status.polled           = out_ch.polled;
			seen_status.clear_flags      = out_ch.clear_flags;
			seen_status.send_frame       = out_ch.send_frame;
			seen_status.frame_brightness = out_ch.frame_brightness;
			seen_status.render_enable    = out_ch.render_enable;
			seen_status.blank_now        = out_ch.blank_now;
			seen_status.trigger_flags    = out_ch.trigger_flags;
			seen_status.recent_flags     = out_ch.recent_flags;
			seen_status.last_in_run      = out_ch.last_in_run;
			sb.check_result(seen_status);
		end
	end

	// one tick item: optional gap cycles, then hold valid until it is taken
	task automatic send_tick(input bit ok, input logic [FLAG_W-1:0] flags,
		input logic [BRI_W-1:0] bri);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid              <= 1'b1;
		in_ch.status_ok          <= ok;
		in_ch.key_flags          <= flags;
		in_ch.logical_brightness <= bri;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_tick(ok, flags, bri);
		ticks_sent++;
	endtask

	// stop offering and wait for every predicted status item to come back
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic [BRI_W-1:0] pick_bri();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return '1;
			default: return BRI_W'($urandom_range(255, 0));
		endcase
	endfunction

	// press, hold with occasional long-press and stray flags, then release;
	// edges repeat a few ticks so that they land on a poll slot
	task automatic key_session(input int poll);
		int                edge_reps;
		int                hold_len;
		int                roll;
		logic [FLAG_W-1:0] flags;
		logic [BRI_W-1:0]  bri;
		edge_reps = (poll > 6) ? 6 : poll;
		bri       = pick_bri();
		repeat (edge_reps)
			send_tick(1'b1, F_PRESS | ($urandom_range(1, 0) ? F_SHORT : F_NONE), bri);
		hold_len = $urandom_range(40, 0);
		repeat (hold_len) begin
			roll = $urandom_range(99, 0);
			if (roll < 6) begin
				flags = F_LONG;
			end else if (roll < 10) begin
				flags = FLAG_W'($urandom_range(15, 0));
				flags = flags & ~F_RELEASE;
			end else begin
				flags = F_NONE;
			end
			if ($urandom_range(15, 0) == 0)
				bri = pick_bri();
			send_tick($urandom_range(19, 0) != 0, flags, bri);
		end
		bri = pick_bri();
		repeat (edge_reps)
			send_tick(1'b1, F_RELEASE | ($urandom_range(1, 0) ? F_SHORT : F_NONE), bri);
	endtask

	// settle, load all three intervals, then mostly key sessions plus noise
	task automatic run_phase(input logic [CFG_W-1:0] poll, input logic [CFG_W-1:0] fb,
		input logic [CFG_W-1:0] rf, input int n_items, input bit stress);
		int target;
		wait_drained();
		write_reg(REG_POLL, poll);
		write_reg(REG_FALLBACK, fb);
		write_reg(REG_REFRESH, rf);
		if (stress)
			pressure_req = 1'b1;
		target = ticks_sent + n_items;
		while (ticks_sent < target) begin
			if ($urandom_range(9, 0) < 7) begin
				key_session(int'(poll));
			end else begin
				repeat ($urandom_range(8, 1))
					send_tick(1'($urandom_range(1, 0)), FLAG_W'($urandom_range(15, 0)),
						BRI_W'($urandom_range(255, 0)));
			end
		end
	endtask

	initial begin
		clk                      = 1'b0;
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = REG_POLL;
		cfg_data                 = '0;
		in_ch.valid              = 1'b0;
		in_ch.status_ok          = 1'b0;
		in_ch.key_flags          = F_NONE;
		in_ch.logical_brightness = '0;
		out_ch.ready             = 1'b0;
		pressure_req             = 1'b0;
		hold_off_left            = 0;
		ticks_sent               = 0;
		cycle_count              = 0;
		sender_idle_pct          = 36;
		receiver_idle_pct        = 67;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed part: poll every tick, short fallback and refresh
		write_reg(REG_POLL, 16'd1);
		write_reg(REG_FALLBACK, 16'd3);
		write_reg(REG_REFRESH, 16'd2);
		send_tick(1'b1, F_NONE, 8'd0);       // quiet poll
		send_tick(1'b0, F_EVERY, 8'd255);    // failed read uses up the slot
		send_tick(1'b1, F_SHORT, 8'd128);    // short press only
		send_tick(1'b1, F_PRESS, 8'd200);    // press starts the hold timer
		send_tick(1'b1, F_NONE, 8'd200);
		send_tick(1'b1, F_NONE, 8'd200);
		send_tick(1'b1, F_NONE, 8'd200);     // fallback hold blanks
		send_tick(1'b1, F_NONE, 8'd90);      // zero frame repeats while held
		send_tick(1'b1, F_NONE, 8'd90);
		send_tick(1'b1, F_NONE, 8'd90);
		send_tick(1'b1, F_RELEASE, 8'd0);    // release restores the saved level
		send_tick(1'b1, F_LONG, 8'd255);     // long press with no press first
		send_tick(1'b0, F_NONE, 8'd0);       // failed read still advances the refresh timer
		send_tick(1'b1, F_LONG, 8'd10);      // long press while blanked
		send_tick(1'b1, F_RELEASE, 8'd77);   // release with a live level
		send_tick(1'b1, F_RELEASE, 8'd33);   // release while not blanked
		send_tick(1'b1, F_EVERY, 8'd0);      // blank and cancel in one tick
		send_tick(1'b1, F_PRESS | F_LONG, 8'd1);
		send_tick(1'b1, F_NONE, 8'd0);
		send_tick(1'b1, F_NONE, 8'd0);
		send_tick(1'b1, F_LONG | F_RELEASE, 8'd0);
		send_tick(1'b1, F_PRESS | F_RELEASE, 8'd255);
		send_tick(1'b1, F_SHORT | F_PRESS, 8'd255);
		send_tick(1'b0, F_NONE, 8'd0);
		send_tick(1'b1, F_SHORT | F_RELEASE, 8'd5);

		// sender idles less than the receiver
		run_phase(16'd1, 16'd1, 16'd1, 250, 1'b0);
		run_phase(16'd2, 16'd6, 16'd3, 300, 1'b0);
		run_phase(16'd3, 16'hFFFF, 16'd1, 150, 1'b0);

		// receiver idles less than the sender
		wait_drained();
		sender_idle_pct   = 67;
		receiver_idle_pct = 36;
		run_phase(16'd1, 16'd10, 16'd4, 300, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b0);
		run_phase(16'd4, 16'd8, 16'd5, 250, 1'b0);

		// full rate both ways, with one long receiver hold-off
		wait_drained();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		run_phase(16'd1, 16'd2, 16'hFFFF, 200, 1'b1);
		run_phase(CFG_W'($urandom_range(4, 1)), CFG_W'($urandom_range(20, 1)),
			CFG_W'($urandom_range(10, 1)), 300, 1'b0);
		run_phase(POLL_RST, FALLBACK_RST, REFRESH_RST, 150, 1'b0);

		wait_drained();
		// keep watching the output to catch any stray status item
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_power_key_safe_blank_sequencer: done, clean");
		end else begin
			$display("tb_power_key_safe_blank_sequencer: done, errors");
		end
		$finish;
	end

endmodule
